>>> design/opcode_signature_checksum_assert.svh
// Assertion macros for the opcode signature checksum block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef OPCODE_SIGNATURE_CHECKSUM_ASSERT_SVH
`define OPCODE_SIGNATURE_CHECKSUM_ASSERT_SVH

// Checked at every rising edge once reset has been released
`define OSC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("osc assertion failed");

// Checked at every rising edge, reset included
`define OSC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("osc assertion failed");

`endif

>>> design/osc_pkg.sv
// Package for the opcode signature checksum block: types, masks, word reduction.
// Used by osc_front, osc_queue, osc_back and opcode_signature_checksum.
`default_nettype none

package osc_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned RotAmt  = 17;
    localparam int unsigned QDepth  = 2;
    localparam int unsigned QPtrW   = 1;
    localparam int unsigned QCntW   = 2;

    localparam logic [WordW-1:0] PrimaryMask = 32'hFC00_0000;
    localparam logic [WordW-1:0] Low6Mask    = 32'h0000_003F;
    localparam logic [WordW-1:0] Mid5Mask    = 32'h0000_07C0;
    localparam logic [WordW-1:0] OperandMask = 32'h03FF_0000;
    localparam logic [WordW-1:0] Low11Mask   = 32'h0000_07FF;

    // Primary opcode codes with special handling
    localparam logic [5:0] OpPairedSingle = 6'd4;
    localparam logic [5:0] OpMulli        = 6'd7;
    localparam logic [5:0] OpSubfic       = 6'd8;
    localparam logic [5:0] OpImmLo        = 6'd10;
    localparam logic [5:0] OpImmHi        = 6'd15;
    localparam logic [5:0] OpGroup19      = 6'd19;
    localparam logic [5:0] OpGroup31      = 6'd31;
    localparam logic [5:0] OpGroup59      = 6'd59;
    localparam logic [5:0] OpGroup63      = 6'd63;
    localparam logic [5:0] OpLdStLo       = 6'd32;
    localparam logic [5:0] OpLdStHi       = 6'd55;

    // Paired-single sub-opcodes that also keep bits 10..6
    localparam logic [5:0] PsSubA = 6'd0;
    localparam logic [5:0] PsSubB = 6'd8;
    localparam logic [5:0] PsSubC = 6'd16;
    localparam logic [5:0] PsSubD = 6'd21;
    localparam logic [5:0] PsSubE = 6'd22;
    localparam logic [5:0] Fp59Limit = 6'd16;

    // Classified word travelling from front to back
    typedef struct packed {
        logic [WordW-1:0] red;
        logic             last;
    } t_item;

    // Reduce an instruction word to its opcode-identifying bits
    function automatic logic [WordW-1:0] reduce_word(input logic [WordW-1:0] w);
        logic [5:0]       p;
        logic [5:0]       sub;
        logic [WordW-1:0] ext;
        p   = w[31:26];
        sub = w[5:0];
        ext = '0;
        unique case (p) inside
            OpPairedSingle: begin
                ext = w & Low6Mask;
                unique case (sub) inside
                    PsSubA, PsSubB, PsSubC, PsSubD, PsSubE: ext = ext | (w & Mid5Mask);
                    default: ;
                endcase
            end
            OpMulli, OpSubfic, [OpImmLo:OpImmHi]: ext = w & OperandMask;
            OpGroup19, OpGroup31, OpGroup63:     ext = w & Low11Mask;
            OpGroup59: begin
                ext = w & Low6Mask;
                if (sub < Fp59Limit) begin
                    ext = ext | (w & Mid5Mask);
                end
            end
            [OpLdStLo:OpLdStHi]: ext = w & OperandMask;
            default: ext = '0;
        endcase
        return (w & PrimaryMask) | ext;
    endfunction

    // Rotate left by the fixed fold amount
    function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v);
        return {v[WordW-RotAmt-1:0], v[WordW-1:WordW-RotAmt]};
    endfunction

endpackage

`default_nettype wire

>>> design/opcode_signature_checksum.sv
// Opcode signature checksum: one word per cycle while the queue has room, front classify -> 2-entry queue -> back fold.
// A last word's checksum is loaded into the result register when the back end takes it from the queue.
// Throughput: 1 word per cycle; only a last word waits, while an unread result blocks it.
// Reset (synchronous, active low) clears the running sum, the queue and the result slot.
// Depends on osc_pkg, osc_front, osc_queue and osc_back.
`default_nettype none

module opcode_signature_checksum (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic [osc_pkg::WordW-1:0] i_instr_word,
    input  wire logic                      i_last_word,
    output logic                           empty,
    input  wire logic                      pop,
    output logic [osc_pkg::WordW-1:0]      o_checksum
);

    osc_pkg::t_item f_item;
    osc_pkg::t_item q_item;
    logic           q_push;
    logic           q_full;
    logic           q_vld;
    logic           q_pop;

    // Classify incoming requests
    osc_front u_front (
        .i_push       (push),
        .i_instr_word (i_instr_word),
        .i_last_word  (i_last_word),
        .i_q_full     (q_full),
        .o_item       (f_item),
        .o_q_push     (q_push)
    );

    // Decoupling queue
    osc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_vld   (q_vld)
    );

    // Fold and deliver
    osc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (q_item),
        .i_q_vld    (q_vld),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_checksum (o_checksum)
    );

    assign full = q_full;

endmodule

`default_nettype wire

>>> design/osc_front.sv
// Front end: accepts instruction words and classifies them into reduced words.
// Depends on osc_pkg (t_item, reduce_word).
`default_nettype none

module osc_front (
    input  wire logic                      i_push,
    input  wire logic [osc_pkg::WordW-1:0] i_instr_word,
    input  wire logic                      i_last_word,
    input  wire logic                      i_q_full,
    output osc_pkg::t_item                 o_item,
    output logic                           o_q_push
);

    // Request goes into the queue only when it has room
    always_comb begin
        o_item.red  = osc_pkg::reduce_word(i_instr_word);
        o_item.last = i_last_word;
        o_q_push    = i_push && !i_q_full;
    end

endmodule

`default_nettype wire

>>> design/osc_queue.sv
// Two-entry queue decoupling the front classifier from the back accumulator.
// Depends on osc_pkg (t_item, queue sizing).
`default_nettype none

module osc_queue (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire osc_pkg::t_item i_item,
    output logic          o_full,
    input  wire logic     i_pop,
    output osc_pkg::t_item o_item,
    output logic          o_vld
);

    osc_pkg::t_item                  r_mem [osc_pkg::QDepth];
    logic [osc_pkg::QPtrW-1:0]       r_wr;
    logic [osc_pkg::QPtrW-1:0]       n_wr;
    logic [osc_pkg::QPtrW-1:0]       r_rd;
    logic [osc_pkg::QPtrW-1:0]       n_rd;
    logic [osc_pkg::QCntW-1:0]       r_cnt;
    logic [osc_pkg::QCntW-1:0]       n_cnt;
    logic                            do_pop;

    // Status and next pointers
    always_comb begin
        o_full = (r_cnt == osc_pkg::QCntW'(osc_pkg::QDepth));
        o_vld  = (r_cnt != '0);
        o_item = r_mem[r_rd];
        do_pop = i_pop && o_vld;
        n_wr   = i_push ? r_wr + 1'b1 : r_wr;
        n_rd   = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt  = r_cnt + osc_pkg::QCntW'(i_push) - osc_pkg::QCntW'(do_pop);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> design/osc_back.sv
// Back end: folds reduced words into the running sum and holds the result.
// Depends on osc_pkg and the assertion macros in opcode_signature_checksum_assert.svh.
`default_nettype none
`include "opcode_signature_checksum_assert.svh"

module osc_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire osc_pkg::t_item            i_item,
    input  wire logic                      i_q_vld,
    output logic                           o_q_pop,
    input  wire logic                      i_pop,
    output logic                           o_empty,
    output logic [osc_pkg::WordW-1:0]      o_checksum
);

    logic [osc_pkg::WordW-1:0] r_sum;
    logic [osc_pkg::WordW-1:0] n_sum;
    logic [osc_pkg::WordW-1:0] fold;
    logic [osc_pkg::WordW-1:0] r_out;
    logic                      r_out_vld;
    logic                      n_out_vld;
    logic                      take;
    logic                      slot_free;

    // A last word needs the result slot; other words always proceed
    always_comb begin
        slot_free = !r_out_vld || i_pop;
        take      = i_q_vld && (!i_item.last || slot_free);
        fold      = osc_pkg::rotl(r_sum) ^ i_item.red;
        n_sum     = r_sum;
        n_out_vld = r_out_vld && !i_pop;
        if (take) begin
            n_sum = i_item.last ? '0 : fold;
            if (i_item.last) begin
                n_out_vld = 1'b1;
            end
        end
        o_q_pop    = take;
        o_empty    = !r_out_vld;
        o_checksum = r_out;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_sum     <= n_sum;
            r_out_vld <= n_out_vld;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (take && i_item.last) begin
            r_out <= fold;
        end
    end

    `OSC_ASSERT(a_sum_clears, i_clk, i_rst_n, take && i_item.last |=> r_sum == '0)
    `OSC_ASSERT(a_fold, i_clk, i_rst_n, take && !i_item.last |=> r_sum == $past(fold))
    `OSC_ASSERT(a_result_loaded, i_clk, i_rst_n, take && i_item.last |=> r_out_vld && r_out == $past(fold))
    `OSC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !r_out_vld && r_sum == '0)

endmodule

`default_nettype wire

>>> tb/osc_sum_checker.sv
// Checker for the opcode signature checksum block: watches both sides, predicts checksums.
// Depends on osc_pkg for widths, opcode codes and masks.
module osc_sum_checker
    import osc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             full,
    input  logic [WordW-1:0] instr_word,
    input  logic             last_word,
    input  logic             empty,
    input  logic             pop,
    input  logic [WordW-1:0] checksum,
    output int               fail_cnt,
    output int               sums_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ReportMax = 10;

    logic [WordW-1:0] sig_sum;
    logic [WordW-1:0] sums_due[$];
    int               err_cnt;

    // Keep only the bits that identify the opcode of one instruction word
    function automatic logic [WordW-1:0] reduce_opcode_bits(input logic [WordW-1:0] w);
        logic [5:0]       op;
        logic [5:0]       low6;
        logic [WordW-1:0] keep;
        op   = w[31:26];
        low6 = w[5:0];
        keep = PrimaryMask;
        if (op == OpPairedSingle) begin
            keep = keep | Low6Mask;
            if (low6 == PsSubA || low6 == PsSubB || low6 == PsSubC ||
                low6 == PsSubD || low6 == PsSubE) begin
                keep = keep | Mid5Mask;
            end
        end else if (op == OpMulli || op == OpSubfic ||
                     (op >= OpImmLo && op <= OpImmHi) ||
                     (op >= OpLdStLo && op <= OpLdStHi)) begin
            keep = keep | OperandMask;
        end else if (op == OpGroup19 || op == OpGroup31 || op == OpGroup63) begin
            keep = keep | Low11Mask;
        end else if (op == OpGroup59) begin
            keep = keep | Low6Mask;
            if (low6 < Fp59Limit) begin
                keep = keep | Mid5Mask;
            end
        end
        return w & keep;
    endfunction

    // Fold one word into the running signature
    function automatic logic [WordW-1:0] fold_sig(input logic [WordW-1:0] s,
                                                  input logic [WordW-1:0] w);
        return ((s << RotAmt) | (s >> (WordW - RotAmt))) ^ reduce_opcode_bits(w);
    endfunction

    // Compare popped checksums first (a request cannot come out the cycle it goes in),
    // then fold in the accepted word
    always @(posedge clk) begin
        if (!rst_n) begin
            sig_sum = '0;
            sums_due.delete();
            err_cnt = 0;
        end else begin
            if (pop && !empty) begin
                if (sums_due.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= ReportMax)
                        $display("[%0t] unexpected checksum %08h", $time, checksum);
                end else begin
                    if (checksum !== sums_due[0]) begin
                        err_cnt++;
                        if (err_cnt <= ReportMax)
                            $display("[%0t] checksum mismatch: expected %08h, got %08h",
                                     $time, sums_due[0], checksum);
                    end
                    void'(sums_due.pop_front());
                end
            end
            if (push && !full) begin
                sig_sum = fold_sig(sig_sum, instr_word);
                if (last_word) begin
                    sums_due.push_back(sig_sum);
                    sig_sum = '0;
                end
            end
        end
        fail_cnt     <= err_cnt;
        sums_pending <= sums_due.size();
    end

endmodule

>>> tb/tb_opcode_signature_checksum.sv
// Testbench top for opcode_signature_checksum: clock, reset, word stream, pop pattern, verdict.
// Depends on osc_pkg, the block itself and the osc_sum_checker module.
module tb_opcode_signature_checksum;
    import osc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WordTarget    = 1400;
    localparam int HoldStart     = 1200;
    localparam int HoldLen       = 300;
    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 8;

    logic             i_clk;
    logic             i_rst_n;
    logic             push;
    logic             full;
    logic [WordW-1:0] i_instr_word;
    logic             i_last_word;
    logic             empty;
    logic             pop;
    logic [WordW-1:0] o_checksum;
    int               fail_cnt;
    int               sums_pending;
    int               words_sent;
    int               burst_left;

    opcode_signature_checksum dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_instr_word (i_instr_word),
        .i_last_word  (i_last_word),
        .empty        (empty),
        .pop          (pop),
        .o_checksum   (o_checksum)
    );

    osc_sum_checker u_checker (
        .clk          (i_clk),
        .rst_n        (i_rst_n),
        .push         (push),
        .full         (full),
        .instr_word   (i_instr_word),
        .last_word    (i_last_word),
        .empty        (empty),
        .pop          (pop),
        .checksum     (o_checksum),
        .fail_cnt     (fail_cnt),
        .sums_pending (sums_pending)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [WordW-1:0] word_of(input logic [5:0] op, input logic [25:0] rest);
        return {op, rest};
    endfunction

    // Offer one word until accepted, then maybe open a gap before the next burst
    task automatic push_word(input logic [WordW-1:0] w, input logic is_last);
        int gap;
        push         <= 1'b1;
        i_instr_word <= w;
        i_last_word  <= is_last;
        do @(posedge i_clk); while (full);
        words_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            // a gapless stretch in the middle of the run
            gap = (words_sent > 600 && words_sent < 800) ? 0 :
                  ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Random word, biased toward the sub-opcode decode of paired-single and group 59
    function automatic logic [WordW-1:0] rand_word();
        logic [WordW-1:0] w;
        logic [5:0]       sub;
        w = $urandom;
        case ($urandom_range(0, 9))
            0, 1: begin
                case ($urandom_range(0, 5))
                    0:       sub = PsSubA;
                    1:       sub = PsSubB;
                    2:       sub = PsSubC;
                    3:       sub = PsSubD;
                    4:       sub = PsSubE;
                    default: sub = 6'($urandom_range(0, 63));
                endcase
                w = {OpPairedSingle, w[25:6], sub};
            end
            2: w = {OpGroup59, w[25:6], 6'($urandom_range(0, 31))};
            default: ;
        endcase
        return w;
    endfunction

    // Stimulus and verdict
    initial begin
        int flen;
        i_rst_n      <= 1'b0;
        push         <= 1'b0;
        i_instr_word <= '0;
        i_last_word  <= 1'b0;
        words_sent   = 0;
        burst_left   = 8;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes and each branch of the opcode decode
        push_word('0, 1'b1);
        push_word('1, 1'b1);
        push_word(word_of(OpPairedSingle, {20'hFFFFF, PsSubA}), 1'b0);
        push_word(word_of(OpPairedSingle, {20'hFFFFF, PsSubB}), 1'b0);
        push_word(word_of(OpPairedSingle, {20'hFFFFF, PsSubC}), 1'b0);
        push_word(word_of(OpPairedSingle, {20'hFFFFF, PsSubD}), 1'b0);
        push_word(word_of(OpPairedSingle, {20'hFFFFF, PsSubE}), 1'b0);
        push_word(word_of(OpPairedSingle, '1), 1'b1);
        push_word(word_of(OpMulli, '1), 1'b0);
        push_word(word_of(OpSubfic, '1), 1'b0);
        // the opcode between subfic and the immediate group keeps only the primary
        push_word(word_of(OpImmLo - 6'd1, '1), 1'b0);
        push_word(word_of(OpImmLo, '1), 1'b0);
        push_word(word_of(OpImmHi, '1), 1'b1);
        push_word(word_of(OpGroup19, '1), 1'b0);
        push_word(word_of(OpGroup31, '1), 1'b1);
        push_word(word_of(OpGroup59, {20'hFFFFF, Fp59Limit - 6'd1}), 1'b0);
        push_word(word_of(OpGroup59, {20'hFFFFF, Fp59Limit}), 1'b1);
        push_word(word_of(OpLdStLo, '1), 1'b0);
        push_word(word_of(OpLdStHi, '1), 1'b0);
        push_word(word_of(OpLdStHi + 6'd1, '1), 1'b1);

        // random functions of random length, a few long ones
        while (words_sent < WordTarget) begin
            flen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            for (int k = 1; k <= flen; k++)
                push_word(rand_word(), k == flen);
        end
        push <= 1'b0;

        do @(posedge i_clk); while (sums_pending != 0);
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Result side: rotating stall pattern, plus one long hold to back the block up
    initial begin
        logic [31:0] cyc;
        cyc = '0;
        pop <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (cyc >= HoldStart && cyc < HoldStart + HoldLen)
                pop <= 1'b0;
            else begin
                case (cyc[9:8])
                    2'd0: pop <= 1'b1;
                    2'd1: pop <= ($urandom_range(0, 9) < 7);
                    2'd2: pop <= (cyc % 5 != 0);
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
            @(posedge i_clk);
            cyc++;
        end
    end

    // Watchdog on cycles with no request moving on either side
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if ((push && !full) || (pop && !empty))
                    idle = 0;
                else
                    idle++;
                if (idle >= WatchdogLimit) begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

endmodule
